// ===== sv/mfc_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the motor feedback
// frame checker. No dependencies; the block's modules use it.
package mfc_pkg;

  localparam int unsigned FrameLast = 9;
  localparam logic [3:0]  PosIdle   = 4'd10;
  localparam logic [7:0]  CrcPoly   = 8'h8C;
  localparam logic [7:0]  CrcInit   = 8'h00;

  localparam logic [7:0]  CfgExpectedId   = 8'd0;
  localparam logic [7:0]  CfgReplyMode    = 8'd1;
  localparam logic [7:0]  ExpectedIdReset = 8'd1;
  localparam logic [7:0]  ReplyModeReset  = 8'd0;

  // Frame byte positions that carry payload
  localparam logic [3:0] PosId      = 4'd0;
  localparam logic [3:0] PosMode    = 4'd1;
  localparam logic [3:0] PosCurHi   = 4'd2;
  localparam logic [3:0] PosCurLo   = 4'd3;
  localparam logic [3:0] PosSpdHi   = 4'd4;
  localparam logic [3:0] PosSpdLo   = 4'd5;
  localparam logic [3:0] PosFault   = 4'd8;
  localparam logic [3:0] PosCrc     = 4'(FrameLast);

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StIdFail   = 2'd1,
    StModeFail = 2'd2,
    StCrcFail  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } item_t;

  // Input register contents handed to the frame tracker
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic [7:0] motor_addr;
    logic [7:0] reply_mode_code;
  } cfg_t;

  // Reflected CRC-8, one byte, bit-by-bit over eight steps
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/mfc_if.sv =====
// Valid/ready channel interfaces for the frame checker: frame bytes in,
// check results out, configuration writes. Depends on nothing.
interface mfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;
  modport source (output valid, frame_byte, frame_start, input ready);
  modport sink   (input valid, frame_byte, frame_start, output ready);
endinterface

interface mfc_result_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [15:0] raw_current;
  logic signed [15:0] speed_rpm;
  logic        [7:0]  fault_code;
  modport source (output valid, status, raw_current, speed_rpm, fault_code, input ready);
  modport sink   (input valid, status, raw_current, speed_rpm, fault_code, output ready);
endinterface

interface mfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/mfc_in_stage.sv =====
// Input register of the frame checker: captures one byte beat and holds it
// until the tracker takes it. Depends on mfc_pkg and mfc_byte_if.
module mfc_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  mfc_byte_if.sink        in_i,
  input  logic            advance_i,
  output mfc_pkg::stage_t stage_o
);

  logic           valid_q, valid_d;
  mfc_pkg::item_t item_q;

  // Take a new beat when empty or when the held one moves on
  assign in_i.ready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.frame_byte  <= in_i.frame_byte;
      item_q.frame_start <= in_i.frame_start;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// ===== sv/mfc_frame_track.sv =====
// Frame tracker: position counter, running CRC, field holds and the result
// register. Depends on mfc_pkg and mfc_result_if.
module mfc_frame_track (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mfc_pkg::stage_t stage_i,
  input  mfc_pkg::cfg_t   cfg_i,
  output logic            advance_o,
  mfc_result_if.source    out_o
);

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic        id_ok_q, id_ok_d;
  logic        mode_ok_q, mode_ok_d;
  logic [15:0] cur_q, cur_d;
  logic [15:0] spd_q, spd_d;
  logic [7:0]  fault_q, fault_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_status_q;
  logic [15:0] out_cur_q;
  logic [15:0] out_spd_q;
  logic [7:0]  out_fault_q;

  logic        out_free;
  logic        makes_result;
  logic [3:0]  pos_eff;
  logic [7:0]  crc_base;
  logic [7:0]  b;
  mfc_pkg::status_e status;

  assign b        = stage_i.item.frame_byte;
  assign pos_eff  = stage_i.item.frame_start ? mfc_pkg::PosId : pos_q;
  assign crc_base = stage_i.item.frame_start ? mfc_pkg::CrcInit : crc_q;

  // A held beat ending a frame waits for room in the result register
  assign out_free     = !out_valid_q || out_o.ready;
  assign makes_result = stage_i.valid && (pos_eff == mfc_pkg::PosCrc);
  assign advance_o    = stage_i.valid && (!makes_result || out_free);

  // Check priority: id, then mode, then crc
  always_comb begin
    if (!id_ok_q) begin
      status = mfc_pkg::StIdFail;
    end else if (!mode_ok_q) begin
      status = mfc_pkg::StModeFail;
    end else if (b != crc_q) begin
      status = mfc_pkg::StCrcFail;
    end else begin
      status = mfc_pkg::StOk;
    end
  end

  // Advance the frame state by one byte
  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    id_ok_d   = id_ok_q;
    mode_ok_d = mode_ok_q;
    cur_d     = cur_q;
    spd_d     = spd_q;
    fault_d   = fault_q;
    if (advance_o && pos_eff <= mfc_pkg::PosCrc) begin
      if (pos_eff < mfc_pkg::PosCrc) begin
        crc_d = mfc_pkg::crc8_update(crc_base, b);
        pos_d = pos_eff + 4'd1;
      end else begin
        pos_d = mfc_pkg::PosIdle;
      end
      case (pos_eff)
        mfc_pkg::PosId:    id_ok_d     = (b == cfg_i.motor_addr);
        mfc_pkg::PosMode:  mode_ok_d   = (b == cfg_i.reply_mode_code);
        mfc_pkg::PosCurHi: cur_d[15:8] = b;
        mfc_pkg::PosCurLo: cur_d[7:0]  = b;
        mfc_pkg::PosSpdHi: spd_d[15:8] = b;
        mfc_pkg::PosSpdLo: spd_d[7:0]  = b;
        mfc_pkg::PosFault: fault_d     = b;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= mfc_pkg::PosIdle;
      crc_q     <= mfc_pkg::CrcInit;
      id_ok_q   <= 1'b0;
      mode_ok_q <= 1'b0;
      cur_q     <= '0;
      spd_q     <= '0;
      fault_q   <= '0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      id_ok_q   <= id_ok_d;
      mode_ok_q <= mode_ok_d;
      cur_q     <= cur_d;
      spd_q     <= spd_d;
      fault_q   <= fault_d;
    end
  end

  // Result register: load on the last byte, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance_o && makes_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the status; zero the fields of a failed frame
  always_ff @(posedge clk_i) begin
    if (advance_o && makes_result) begin
      out_status_q <= status;
      out_cur_q    <= (status == mfc_pkg::StOk) ? cur_q   : 16'd0;
      out_spd_q    <= (status == mfc_pkg::StOk) ? spd_q   : 16'd0;
      out_fault_q  <= (status == mfc_pkg::StOk) ? fault_q : 8'd0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.raw_current = $signed(out_cur_q);
  assign out_o.speed_rpm   = $signed(out_spd_q);
  assign out_o.fault_code  = out_fault_q;

endmodule

// ===== sv/motor_feedback_frame_checker.sv =====
// Motor feedback frame checker top level: configuration registers, input
// register and frame tracker. Depends on mfc_pkg, mfc_if, mfc_in_stage, mfc_frame_track.
//
// Usage:
//   in_i   carries one byte of a ten-byte reply frame per beat; frame_start
//          marks byte 0 and always restarts the frame. Bytes outside a frame
//          are dropped.
//   out_o  carries one beat per completed frame, after byte 9: status
//          (ok, id, mode or crc mismatch, in that priority), raw current,
//          speed and fault byte; the three fields are zero on any mismatch.
//   cfg_i  writes the motor address (index 0) and reply_mode_code (index 1);
//          it is always ready, other indexes are ignored.
// Throughput is one byte per cycle unless a byte ending a frame waits on a stalled
// result register; the eight-step CRC-8 update is combinational, between the input register and the result register.
// Byte 9 passes the input register, then loads the result register and out_o.valid
// rises; the load waits while the result register is still full and not taken.
// When out_o stalls, the result register holds; one more byte is buffered in
// the input register and in_i.ready drops only if that byte ends a frame.
// Reset clears the frame state to idle, the motor address to 1 and
// reply_mode_code to 0; no result is pending after reset.
module motor_feedback_frame_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  mfc_cfg_if.sink      cfg_i,
  mfc_byte_if.sink     in_i,
  mfc_result_if.source out_o
);

  mfc_pkg::cfg_t   cfg_q, cfg_d;
  mfc_pkg::stage_t stage;
  logic            advance;

  assign cfg_i.ready = 1'b1;

  // Write the addressed configuration register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        mfc_pkg::CfgExpectedId: cfg_d.motor_addr      = cfg_i.data;
        mfc_pkg::CfgReplyMode:  cfg_d.reply_mode_code = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motor_addr      <= mfc_pkg::ExpectedIdReset;
      cfg_q.reply_mode_code <= mfc_pkg::ReplyModeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mfc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  mfc_frame_track u_frame_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .cfg_i     (cfg_q),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule

// ===== sv/mfc_port_checker.sv =====
// Port-level assertions for the frame checker, bound to the top level.
// Depends on mfc_pkg and motor_feedback_frame_checker.
module mfc_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_current,
  input logic [15:0] out_speed,
  input logic [7:0]  out_fault
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_current) && $stable(out_speed) && $stable(out_fault))
  else $error("stalled result changed");

  // A failed frame carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != mfc_pkg::StOk |->
      out_current == 16'd0 && out_speed == 16'd0 && out_fault == 8'd0)
  else $error("failed frame with nonzero fields");

  // Input backpressure only comes from a stalled full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
  else $error("input stalled without output stall");

  // A new result must be preceded by a byte accepted at the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
  else $error("result without accepted byte");

endmodule

bind motor_feedback_frame_checker mfc_port_checker u_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_status  (out_o.status),
  .out_current (out_o.raw_current),
  .out_speed   (out_o.speed_rpm),
  .out_fault   (out_o.fault_code)
);

// ===== sim/mfc_reply_checker.sv =====
// Reply checker for the motor feedback frame checker: watches the byte,
// result and register channels, predicts each reply and compares it.
// Depends on mfc_pkg and the channel interfaces in mfc_if.
module mfc_reply_checker
  import mfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mfc_cfg_if          cfg_i,
  mfc_byte_if         in_i,
  mfc_result_if       out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned replies_o,
  output int unsigned good_replies_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] current;
    logic signed [15:0] speed;
    logic        [7:0]  fault;
  } reply_t;

  // Predicted frame state and register copies
  cfg_t        regs_q;
  logic [3:0]  pos_q;
  logic [7:0]  crc_q;
  logic        id_ok_q;
  logic        mode_ok_q;
  logic [15:0] current_q;
  logic [15:0] speed_q;
  logic [7:0]  fault_q;
  reply_t      expected_replies [$];

  // Feed the byte in LSB first, one polynomial step per bit
  function automatic logic [7:0] crc8_reflected(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= ReportLimit) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Advance the frame by one byte; queue a reply when byte 9 lands
  task automatic take_frame_byte(input logic [7:0] b, input logic start);
    reply_t r;
    if (start) begin
      pos_q = PosId;
      crc_q = CrcInit;
    end
    // Drop bytes outside a frame
    if (pos_q > PosCrc) begin
      return;
    end
    if (pos_q != PosCrc) begin
      crc_q = crc8_reflected(crc_q, b);
    end
    case (pos_q)
      PosId:    id_ok_q = (b == regs_q.motor_addr);
      PosMode:  mode_ok_q = (b == regs_q.reply_mode_code);
      PosCurHi: current_q[15:8] = b;
      PosCurLo: current_q[7:0] = b;
      PosSpdHi: speed_q[15:8] = b;
      PosSpdLo: speed_q[7:0] = b;
      PosFault: fault_q = b;
      default:  ;
    endcase
    if (pos_q != PosCrc) begin
      pos_q = pos_q + 4'd1;
      return;
    end
    pos_q = PosIdle;
    // Id wins over mode, mode over crc; payload only on a clean frame
    r = '0;
    if (!id_ok_q) begin
      r.status = StIdFail;
    end else if (!mode_ok_q) begin
      r.status = StModeFail;
    end else if (b != crc_q) begin
      r.status = StCrcFail;
    end else begin
      r.status  = StOk;
      r.current = current_q;
      r.speed   = speed_q;
      r.fault   = fault_q;
    end
    expected_replies.push_back(r);
  endtask

  // Compare one reply beat with the oldest prediction
  task automatic check_reply();
    reply_t want;
    replies_o++;
    if (expected_replies.size() == 0) begin
      note_failure($sformatf("reply beat with nothing predicted: status %0d current %0d",
                             out_i.status, out_i.raw_current));
      return;
    end
    want = expected_replies.pop_front();
    if (out_i.status !== want.status || out_i.raw_current !== want.current ||
        out_i.speed_rpm !== want.speed || out_i.fault_code !== want.fault) begin
      note_failure($sformatf(
        "reply %0d exp/act status %0d/%0d current %0d/%0d speed %0d/%0d fault %0h/%0h",
        replies_o, want.status, out_i.status, want.current, out_i.raw_current,
        want.speed, out_i.speed_rpm, want.fault, out_i.fault_code));
    end else if (want.status == StOk) begin
      good_replies_o++;
    end
  endtask

  // Sample all channels on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.motor_addr      = ExpectedIdReset;
      regs_q.reply_mode_code = ReplyModeReset;
      pos_q          = PosIdle;
      crc_q          = CrcInit;
      id_ok_q        = 1'b0;
      mode_ok_q      = 1'b0;
      current_q      = '0;
      speed_q        = '0;
      fault_q        = '0;
      expected_replies.delete();
      fail_count_o   = 0;
      replies_o      = 0;
      good_replies_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgExpectedId: regs_q.motor_addr = cfg_i.data;
          CfgReplyMode:  regs_q.reply_mode_code = cfg_i.data;
          default:       ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        take_frame_byte(in_i.frame_byte, in_i.frame_start);
      end
      if (out_i.valid && out_i.ready) begin
        check_reply();
      end
    end
    pending_o = expected_replies.size();
  end

endmodule

// ===== sim/motor_feedback_frame_checker_tb.sv =====
// Testbench top for the motor feedback frame checker: clock, reset, frame
// stimulus, register writes and the verdict. Depends on mfc_pkg, mfc_if,
// mfc_reply_checker and the block itself.
module motor_feedback_frame_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfc_pkg::*;

  localparam int unsigned ResetCycles     = 8;
  localparam int unsigned SettleCycles    = 8;
  localparam int unsigned LongStallCycles = 400;
  localparam int unsigned WatchdogLimit   = 4000;
  localparam int unsigned PhaseBytes      = 640;

  logic clk_i;
  logic rst_ni;

  mfc_cfg_if    cfg_b ();
  mfc_byte_if   in_b ();
  mfc_result_if out_b ();

  int unsigned fail_count;
  int unsigned pending_replies;
  int unsigned reply_count;
  int unsigned good_count;

  int unsigned sender_idle_pct = 0;
  int unsigned sink_idle_pct   = 0;
  int unsigned stall_requests  = 0;
  int unsigned frame_bytes     = 0;
  logic [7:0]  cur_id;
  logic [7:0]  cur_mode;

  motor_feedback_frame_checker i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_b),
    .in_i   (in_b),
    .out_o  (out_b)
  );

  mfc_reply_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_b),
    .in_i           (in_b),
    .out_i          (out_b),
    .fail_count_o   (fail_count),
    .pending_o      (pending_replies),
    .replies_o      (reply_count),
    .good_replies_o (good_count)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Drive result ready; a requested long hold-off overrides the random mix
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned stall_served;
    stall_left   = 0;
    stall_served = 0;
    out_b.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_requests != stall_served) begin
        stall_served = stall_requests;
        stall_left   = LongStallCycles;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_b.ready <= 1'b0;
      end else begin
        out_b.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // End the run when no beat moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_b.valid && in_b.ready) || (out_b.valid && out_b.ready) ||
          (cfg_b.valid && cfg_b.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat for %0d cycles", WatchdogLimit);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Mostly random words, sometimes the signed extremes, all ones or zero
  function automatic logic [15:0] pick_word();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one byte beat, idling at random first; leave valid high on return
  task automatic send_byte(input logic [7:0] data, input logic start);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_b.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_b.valid       <= 1'b1;
    in_b.frame_byte  <= data;
    in_b.frame_start <= start;
    @(posedge clk_i);
    while (in_b.ready !== 1'b1) begin
      @(posedge clk_i);
    end
  endtask

  // Build a full reply frame and send bytes first..last of it
  task automatic send_frame(input logic [7:0] id, input logic [7:0] mode,
                            input logic [15:0] current, input logic [15:0] speed,
                            input logic [15:0] spare, input logic [7:0] fault,
                            input bit crc_bad, input int unsigned first,
                            input int unsigned last);
    logic [7:0] fb [10];
    logic [7:0] crc;
    fb[0] = id;
    fb[1] = mode;
    fb[2] = current[15:8];
    fb[3] = current[7:0];
    fb[4] = speed[15:8];
    fb[5] = speed[7:0];
    fb[6] = spare[15:8];
    fb[7] = spare[7:0];
    fb[8] = fault;
    crc = CrcInit;
    for (int k = 0; k < FrameLast; k++) begin
      crc = crc8_byte(crc, fb[k]);
    end
    fb[FrameLast] = crc_bad ? (crc ^ 8'($urandom_range(255, 1))) : crc;
    for (int unsigned k = first; k <= last; k++) begin
      send_byte(fb[k], k == 0);
    end
    frame_bytes += last - first + 1;
  endtask

  // Mostly clean frames; some carry a bad id, mode or crc, some are cut short
  task automatic random_frame();
    bit          id_bad;
    bit          mode_bad;
    bit          crc_bad;
    int unsigned last;
    id_bad   = $urandom_range(99) < 15;
    mode_bad = $urandom_range(99) < 15;
    crc_bad  = $urandom_range(99) < 15;
    last     = ($urandom_range(99) < 8) ? $urandom_range(FrameLast - 1, 0) : FrameLast;
    send_frame(id_bad ? (cur_id ^ 8'($urandom_range(255, 1))) : cur_id,
               mode_bad ? (cur_mode ^ 8'($urandom_range(255, 1))) : cur_mode,
               pick_word(), pick_word(), 16'($urandom), 8'($urandom),
               crc_bad, 0, last);
    // Stray bytes without a start flag
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(3, 1)) begin
        send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // Stop offering, wait for every predicted reply, then let the pipe empty
  task automatic settle();
    in_b.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_replies != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both registers and one unused index
  task automatic write_regs(input logic [7:0] id, input logic [7:0] mode);
    cfg_b.valid <= 1'b1;
    cfg_b.index <= CfgExpectedId;
    cfg_b.data  <= id;
    @(posedge clk_i);
    while (cfg_b.ready !== 1'b1) @(posedge clk_i);
    cfg_b.index <= CfgReplyMode;
    cfg_b.data  <= mode;
    @(posedge clk_i);
    while (cfg_b.ready !== 1'b1) @(posedge clk_i);
    cfg_b.index <= 8'($urandom_range(255, CfgReplyMode + 1));
    cfg_b.data  <= 8'($urandom);
    @(posedge clk_i);
    while (cfg_b.ready !== 1'b1) @(posedge clk_i);
    cfg_b.valid <= 1'b0;
    cur_id   = id;
    cur_mode = mode;
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input bit long_stall);
    int unsigned start_count;
    sender_idle_pct = src_pct;
    sink_idle_pct   = snk_pct;
    start_count     = frame_bytes;
    if (long_stall) begin
      stall_requests++;
    end
    while (frame_bytes - start_count < PhaseBytes) begin
      random_frame();
    end
  endtask

  initial begin : stimulus
    rst_ni           <= 1'b0;
    in_b.valid       <= 1'b0;
    in_b.frame_byte  <= '0;
    in_b.frame_start <= 1'b0;
    cfg_b.valid      <= 1'b0;
    cfg_b.index      <= '0;
    cfg_b.data       <= '0;
    cur_id   = ExpectedIdReset;
    cur_mode = ReplyModeReset;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes while idle are dropped
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // Partial frame, dropped by the next start
    send_frame(cur_id, cur_mode, 16'h1234, 16'h5678, 16'h9ABC, 8'h5A, 0, 0, 1);
    // Clean frame with payload extremes, reset register values
    send_frame(cur_id, cur_mode, 16'h8000, 16'h7FFF, 16'hFFFF, 8'hFF, 0, 0, FrameLast);
    // Change the mode code after byte 0 has gone in
    send_frame(cur_id, 8'hFF, 16'h7FFF, 16'h8000, 16'h0000, 8'h00, 0, 0, 0);
    settle();
    write_regs(cur_id, 8'hFF);
    send_frame(cur_id, 8'hFF, 16'h7FFF, 16'h8000, 16'h0000, 8'h00, 0, 1, FrameLast);

    // Random phases with different idling mixes and register settings
    settle();
    write_regs(8'hFF, 8'h00);
    run_phase(18, 66, 1'b1);
    settle();
    write_regs(8'h00, 8'($urandom));
    run_phase(66, 18, 1'b0);
    settle();
    write_regs(8'($urandom), 8'hFF);
    run_phase(0, 0, 1'b1);
    settle();

    $display("Summary: %0d frame bytes sent, %0d reply beats checked, %0d clean frames",
             frame_bytes, reply_count, good_count);
    $display("Summary: idle drops, restarts, mid-frame register change, long output hold-off");
    if (fail_count == 0 && pending_replies == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mfc_pkg.sv
sv/mfc_if.sv
sv/mfc_in_stage.sv
sv/mfc_frame_track.sv
sv/motor_feedback_frame_checker.sv
sv/mfc_port_checker.sv
sim/mfc_reply_checker.sv
sim/motor_feedback_frame_checker_tb.sv
